// ===== hdl/tlmm_pkg.sv =====
// Shared types and constants for the two-level min/max decimator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tlmm_pkg;

	localparam int RATIO_DEF       = 10;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic LEVEL_ONE = 1'b0;
	localparam logic LEVEL_TWO = 1'b1;

	// Control half of one queue entry: up to two result words per sample.
	typedef struct packed {
		logic push;        // entry carries at least one word
		logic dual;        // entry carries two words
		logic word0_level; // level of the first word (second is always level two)
		logic fin;         // last word of the entry ends the array
	} bundle_ctl_t;

endpackage

// ===== hdl/two_level_min_max_decimator.sv =====
// Two-level min/max peak decimator, top level.
// Instantiates tlmm_front, tlmm_queue and tlmm_back; uses tlmm_pkg.
//
// Input channel: sample, last_sample with in_valid / in_stall. A word is taken
// at a rising edge with in_valid high and in_stall low. One sample per cycle is
// accepted unless stalled; window compares and counters act in that cycle.
// Output channel: level, peak_max, peak_min, final_result with out_valid /
// out_stall. Level-one words close every RATIO samples and level-two words
// every RATIO level-one words; at each level the first closes after RATIO/2.
// A sample yields zero, one or two words; a two-word sample emits level one
// first, then level two. Words pass through a queue entry and the output
// register. Throughput: one sample per cycle sustained while out_stall is low;
// the output register drains one word per cycle unless stalled, and a
// four-entry bundle queue absorbs bursts. last_sample flushes open windows
// that are in window zero or hold at least RATIO - RATIO/2 items, marks the
// final word with final_result and restarts both levels for the next array.
// Stall: while out_stall is high the output word holds; queued bundles wait, and
// in_stall rises only once the queue is full.
// Reset (arst_n low): window counters clear, both levels restart at window
// zero, the queue empties and out_valid drops.
`timescale 1ns / 1ps

module two_level_min_max_decimator #(
	parameter int RATIO       = tlmm_pkg::RATIO_DEF,
	parameter int SAMPLE_BITS = tlmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          level,
	output logic signed [SAMPLE_BITS-1:0] peak_max,
	output logic signed [SAMPLE_BITS-1:0] peak_min,
	output logic                          final_result
);

	tlmm_pkg::bundle_ctl_t         push_ctl, head_ctl;
	logic signed [SAMPLE_BITS-1:0] w0_max, w0_min, w1_max, w1_min;
	logic [4*SAMPLE_BITS-1:0]      head_data;
	logic                          accept, full, not_empty, pop;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	tlmm_front #(
		.RATIO       (RATIO),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (sample),
		.last_sample (last_sample),
		.ctl         (push_ctl),
		.w0_max      (w0_max),
		.w0_min      (w0_min),
		.w1_max      (w1_max),
		.w1_min      (w1_min)
	);

	tlmm_queue #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_ctl  (push_ctl),
		.push_data ({w0_max, w0_min, w1_max, w1_min}),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head_ctl  (head_ctl),
		.head_data (head_data)
	);

	tlmm_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (not_empty),
		.head_ctl     (head_ctl),
		.head_data    (head_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.level        (level),
		.peak_max     (peak_max),
		.peak_min     (peak_min),
		.final_result (final_result)
	);

endmodule

// ===== hdl/tlmm_front.sv =====
// Front end: absorbs each accepted sample into the level-one and level-two windows
// and classifies what the sample emits. Depends on tlmm_pkg.
`timescale 1ns / 1ps

module tlmm_front #(
	parameter int RATIO       = tlmm_pkg::RATIO_DEF,
	parameter int SAMPLE_BITS = tlmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output tlmm_pkg::bundle_ctl_t         ctl,
	output logic signed [SAMPLE_BITS-1:0] w0_max,
	output logic signed [SAMPLE_BITS-1:0] w0_min,
	output logic signed [SAMPLE_BITS-1:0] w1_max,
	output logic signed [SAMPLE_BITS-1:0] w1_min
);

	localparam int CNT_W = $clog2(RATIO + 1);
	localparam logic [CNT_W-1:0] HALF  = CNT_W'(RATIO / 2);
	localparam logic [CNT_W-1:0] FULL  = CNT_W'(RATIO);
	localparam logic [CNT_W-1:0] TAIL  = CNT_W'(RATIO - RATIO / 2);

	logic [CNT_W-1:0]              sample_cnt_q, pair_cnt_q;
	logic                          first1_q, first2_q;
	logic signed [SAMPLE_BITS-1:0] max1_q, min1_q, max2_q, min2_q;

	logic [CNT_W-1:0]              c1, p1, p_after;
	logic                          close1, feed1, close2, first2_after, flush2, l2_emit;
	logic signed [SAMPLE_BITS-1:0] max1_n, min1_n, max2_n, min2_n, l2_max, l2_min;

	always_comb begin
		// level one
		if (sample_cnt_q == '0) begin
			max1_n = sample;
			min1_n = sample;
		end else begin
			max1_n = (sample > max1_q) ? sample : max1_q;
			min1_n = (sample < min1_q) ? sample : min1_q;
		end
		c1     = sample_cnt_q + 1'b1;
		close1 = c1 >= (first1_q ? HALF : FULL);
		feed1  = close1 || (last_sample && (first1_q || c1 >= TAIL));

		// level two, fed by the level-one pair
		if (pair_cnt_q == '0) begin
			max2_n = max1_n;
			min2_n = min1_n;
		end else begin
			max2_n = (max1_n > max2_q) ? max1_n : max2_q;
			min2_n = (min1_n < min2_q) ? min1_n : min2_q;
		end
		p1     = pair_cnt_q + 1'b1;
		close2 = feed1 && (p1 >= (first2_q ? HALF : FULL));

		// flush of level two on the last sample
		p_after      = feed1 ? (close2 ? '0 : p1) : pair_cnt_q;
		first2_after = close2 ? 1'b0 : first2_q;
		flush2       = last_sample && (p_after != '0) && (first2_after || p_after >= TAIL);
		l2_emit      = close2 || flush2;
		l2_max       = feed1 ? max2_n : max2_q;
		l2_min       = feed1 ? min2_n : min2_q;

		ctl.push        = accept && (feed1 || l2_emit);
		ctl.dual        = feed1 && l2_emit;
		ctl.word0_level = feed1 ? tlmm_pkg::LEVEL_ONE : tlmm_pkg::LEVEL_TWO;
		ctl.fin         = last_sample;

		w0_max = feed1 ? max1_n : l2_max;
		w0_min = feed1 ? min1_n : l2_min;
		w1_max = l2_max;
		w1_min = l2_min;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_cnt_q <= '0;
			pair_cnt_q   <= '0;
			first1_q     <= 1'b1;
			first2_q     <= 1'b1;
		end else if (accept) begin
			if (last_sample) begin
				// end of array: start over
				sample_cnt_q <= '0;
				pair_cnt_q   <= '0;
				first1_q     <= 1'b1;
				first2_q     <= 1'b1;
			end else begin
				sample_cnt_q <= close1 ? '0 : c1;
				if (close1) begin
					first1_q <= 1'b0;
				end
				if (feed1) begin
					pair_cnt_q <= close2 ? '0 : p1;
					if (close2) begin
						first2_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			max1_q <= max1_n;
			min1_q <= min1_n;
			if (feed1) begin
				max2_q <= max2_n;
				min2_q <= min2_n;
			end
		end
	end

endmodule

// ===== hdl/tlmm_queue.sv =====
// Short queue of result bundles between front and back end.
// Depends on tlmm_pkg for the bundle control type and depth.
`timescale 1ns / 1ps

module tlmm_queue #(
	parameter int SAMPLE_BITS = tlmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlmm_pkg::bundle_ctl_t          push_ctl,
	input  logic [4*SAMPLE_BITS-1:0]       push_data,
	input  logic                           pop,
	output logic                           full,
	output logic                           not_empty,
	output tlmm_pkg::bundle_ctl_t          head_ctl,
	output logic [4*SAMPLE_BITS-1:0]       head_data
);

	localparam int DEPTH = tlmm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tlmm_pkg::bundle_ctl_t    ctl_q  [DEPTH];
	logic [4*SAMPLE_BITS-1:0] data_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]         count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_ctl  = ctl_q[rd_ptr_q];
	assign head_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ctl.push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ctl.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_ctl.push && full && !pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== hdl/tlmm_back.sv =====
// Back end: splits each queued bundle into result words and holds them
// in the output register. Depends on tlmm_pkg.
`timescale 1ns / 1ps

module tlmm_back #(
	parameter int SAMPLE_BITS = tlmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  tlmm_pkg::bundle_ctl_t         head_ctl,
	input  logic [4*SAMPLE_BITS-1:0]      head_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          level,
	output logic signed [SAMPLE_BITS-1:0] peak_max,
	output logic signed [SAMPLE_BITS-1:0] peak_min,
	output logic                          final_result
);

	logic                          valid_q, sub_q, load;
	logic                          level_q, final_q;
	logic signed [SAMPLE_BITS-1:0] max_q, min_q;

	assign load = head_valid && (!valid_q || !out_stall);
	assign pop  = load && (!head_ctl.dual || sub_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= head_ctl.dual && !sub_q;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sub_q) begin
				level_q <= tlmm_pkg::LEVEL_TWO;
				max_q   <= head_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
				min_q   <= head_data[SAMPLE_BITS-1:0];
				final_q <= head_ctl.fin;
			end else begin
				level_q <= head_ctl.word0_level;
				max_q   <= head_data[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
				min_q   <= head_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
				// only the last word of the bundle may end the array
				final_q <= head_ctl.fin && !head_ctl.dual;
			end
		end
	end

	assign out_valid    = valid_q;
	assign level        = level_q;
	assign peak_max     = max_q;
	assign peak_min     = min_q;
	assign final_result = final_q;

	a_second_word_waits: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> head_valid && head_ctl.dual) else $error("second word without bundle");
	a_second_is_level_two: assert property (@(posedge clk) disable iff (!arst_n)
		(load && sub_q) |=> level_q == tlmm_pkg::LEVEL_TWO)
		else $error("second word not level two");

endmodule

// ===== bench/two_level_min_max_decimator_tb.sv =====
// Self-checking bench for the two-level min/max decimator: random and directed
// sample arrays, random idling on both channels, a scoreboard of predicted words.
// Depends on tlmm_pkg and two_level_min_max_decimator.
`timescale 1ns / 1ps

module two_level_min_max_decimator_tb;

	localparam int RATIO = tlmm_pkg::RATIO_DEF;
	localparam int HALF  = RATIO / 2;
	localparam int SW    = tlmm_pkg::SAMPLE_BITS_DEF;

	typedef struct packed {
		logic                 level;
		logic signed [SW-1:0] pmax;
		logic signed [SW-1:0] pmin;
		logic                 fin;
	} peak_word_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] sample      = '0;
	logic                 last_sample = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 level;
	logic signed [SW-1:0] peak_max;
	logic signed [SW-1:0] peak_min;
	logic                 final_result;

	two_level_min_max_decimator #(
		.RATIO(RATIO),
		.SAMPLE_BITS(SW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last_sample(last_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.peak_max(peak_max),
		.peak_min(peak_min),
		.final_result(final_result)
	);

	always #6 clk = ~clk;

	// Envelope predictor: index 0 is level one (samples), index 1 level two (pairs).
	int                   win_cnt [2];
	bit                   win_first [2];
	logic signed [SW-1:0] win_max [2];
	logic signed [SW-1:0] win_min [2];
	peak_word_t           step_words [$];
	peak_word_t           expected_words [$];

	int samples_sent;
	int arrays_sent;
	int words_seen;
	int words_level_two;
	int words_final;
	int bad_words;

	bit tx_gaps;
	bit rx_busy;
	int rx_hold_req;
	int rx_left;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return $signed(SW'($urandom_range(0, 8))) - 16'sd4;
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(1, 25);
		if (r < 90) return $urandom_range(26, 60);
		return $urandom_range(61, 160);
	endfunction

	task automatic clear_windows();
		for (int lv = 0; lv < 2; lv++) begin
			win_cnt[lv]   = 0;
			win_first[lv] = 1'b1;
			win_max[lv]   = '0;
			win_min[lv]   = '0;
		end
	endtask

	// Fold one (max, min) item into a level; report whether its window closed.
	task automatic absorb_item(input logic lv, input logic signed [SW-1:0] hi,
			input logic signed [SW-1:0] lo, output bit closed);
		if (win_cnt[lv] == 0) begin
			win_max[lv] = hi;
			win_min[lv] = lo;
		end else begin
			if (hi > win_max[lv]) win_max[lv] = hi;
			if (lo < win_min[lv]) win_min[lv] = lo;
		end
		win_cnt[lv]++;
		closed = win_cnt[lv] >= (win_first[lv] ? HALF : RATIO);
		if (closed) begin
			win_cnt[lv]   = 0;
			win_first[lv] = 1'b0;
		end
	endtask

	function automatic bit can_flush(logic lv);
		return win_cnt[lv] != 0 && (win_first[lv] || win_cnt[lv] >= RATIO - HALF);
	endfunction

	task automatic emit_pair(input logic lv);
		step_words.push_back('{level: lv, pmax: win_max[lv], pmin: win_min[lv], fin: 1'b0});
	endtask

	task automatic close_level_one();
		bit closed;
		emit_pair(tlmm_pkg::LEVEL_ONE);
		absorb_item(tlmm_pkg::LEVEL_TWO, win_max[tlmm_pkg::LEVEL_ONE],
			win_min[tlmm_pkg::LEVEL_ONE], closed);
		if (closed) emit_pair(tlmm_pkg::LEVEL_TWO);
	endtask

	task automatic predict_sample(input logic signed [SW-1:0] s, input logic is_last);
		bit closed;
		step_words.delete();
		absorb_item(tlmm_pkg::LEVEL_ONE, s, s, closed);
		if (closed) close_level_one();
		if (is_last) begin
			if (can_flush(tlmm_pkg::LEVEL_ONE)) close_level_one();
			if (can_flush(tlmm_pkg::LEVEL_TWO)) emit_pair(tlmm_pkg::LEVEL_TWO);
			if (step_words.size() > 0) step_words[step_words.size() - 1].fin = 1'b1;
			clear_windows();
		end
		foreach (step_words[i]) expected_words.push_back(step_words[i]);
	endtask

	task automatic send_sample(input logic signed [SW-1:0] s, input logic is_last);
		int g;
		in_valid    <= 1'b1;
		sample      <= s;
		last_sample <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_sample(s, is_last);
		samples_sent++;
		if (is_last) arrays_sent++;
		if (tx_gaps) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic send_list(input int vals[$]);
		foreach (vals[i]) send_sample(SW'(vals[i]), i == vals.size() - 1);
	endtask

	task automatic send_random_array(input int len, input bit close_it);
		for (int i = 0; i < len; i++) send_sample(rand_sample(), close_it && i == len - 1);
	endtask

	// Extremes, alternating bit patterns, and the short-array cases.
	task automatic test_directed();
		int v[$];
		tx_gaps = 1'b0;
		rx_busy = 1'b0;
		v = {32767};
		send_list(v);
		v = {-32768};
		send_list(v);
		// window zero closes on the last sample
		v = {-32768, 32767, 21845, -21846, 0};
		send_list(v);
		// short tail after window zero is dropped
		v = {1, -1, 100, -100, 0, 32767, -32768};
		send_list(v);
		// tail of exactly half a window is flushed
		v = {3, -7, 12, 0, -1, -32768, 5, 32767, -2, 9};
		send_list(v);
	endtask

	// Lengths that land on level-two closes, empty final steps and partial tails.
	task automatic test_array_lengths();
		int lens[$];
		lens = {4, 6, 45, 47, 54, 95};
		tx_gaps = 1'b1;
		rx_busy = 1'b1;
		foreach (lens[i]) send_random_array(lens[i], 1'b1);
	endtask

	// Long receiver hold-off with the sender pushing back to back.
	task automatic test_backpressure();
		tx_gaps     = 1'b0;
		rx_busy     = 1'b0;
		rx_hold_req = 300;
		send_random_array(150, 1'b1);
	endtask

	// Drain everything mid-array, then finish the array.
	task automatic test_drain_pause();
		tx_gaps = 1'b1;
		rx_busy = 1'b1;
		send_random_array(23, 1'b0);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		send_random_array(30, 1'b1);
	endtask

	task automatic test_random();
		int first_sample;
		int len;
		first_sample = samples_sent;
		while (samples_sent - first_sample < 220) begin
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_busy = $urandom_range(0, 3) != 0;
			len     = rand_len();
			send_random_array(len, 1'b1);
		end
	endtask

	// Receiver: random stalls when busy, plus a counted hold-off on request.
	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_left     = rx_hold_req;
			rx_hold_req = 0;
		end else if (rx_left == 0 && rx_busy && $urandom_range(0, 3) == 0) begin
			rx_left = gap_len();
		end
		if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		peak_word_t want;
		peak_word_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{level: level, pmax: peak_max, pmin: peak_min, fin: final_result};
			words_seen++;
			if (got.level == tlmm_pkg::LEVEL_TWO) words_level_two++;
			if (got.fin) words_final++;
			if (expected_words.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected word: level=%0d max=%0d min=%0d final=%0d",
						got.level, got.pmax, got.pmin, got.fin);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					bad_words++;
					if (bad_words <= 10)
						$display({"mismatch at word %0d: expected level=%0d max=%0d min=%0d ",
							"final=%0d, got level=%0d max=%0d min=%0d final=%0d"},
							words_seen, want.level, want.pmax, want.pmin, want.fin,
							got.level, got.pmax, got.pmin, got.fin);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		clear_windows();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_array_lengths();
		test_backpressure();
		test_drain_pause();
		test_random();
		in_valid <= 1'b0;
		rx_busy = 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d samples over %0d arrays, with stalls and idle gaps on both sides",
			samples_sent, arrays_sent);
		$display("checked %0d words: %0d level two, %0d marking an array end",
			words_seen, words_level_two, words_final);
		if (bad_words == 0 && expected_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
